/* rtl/joint_accel_bound_limiter_top_defines.svh */
// Assertion macros for the joint acceleration bound limiter.
// The macros expect clk and arst_n to be visible where they are used.
`ifndef JOINT_ACCEL_BOUND_LIMITER_TOP_DEFINES_SVH
`define JOINT_ACCEL_BOUND_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define JABL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define JABL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/jabl_pkg.sv */
`default_nettype none
package jabl_pkg;

	localparam int Q_W       = 32;
	localparam int Q_FRAC    = 16;
	localparam int STEP_W    = 31;
	localparam int LIM_W     = 31;
	localparam int FAC_W     = 40;
	localparam int NUM_W     = 49;
	localparam int CFG_IDX_W = 2;
	localparam int LATENCY   = 9;

	localparam logic [STEP_W-1:0] STEP_TIME_RST   = 31'd66;
	localparam logic [FAC_W-1:0]  INVERSE_RST     = 40'd65536000;
	localparam logic [FAC_W-1:0]  TWO_OVER_SQ_RST = 40'd131072000000;

	localparam logic signed [Q_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_TIME    = 2'd0,
		REG_INVERSE_STEP = 2'd1,
		REG_TWO_OVER_SQ  = 2'd2
	} cfg_reg_t;

endpackage
`default_nettype wire

/* rtl/jabl_scale.sv */
`default_nettype none
module jabl_scale (
	input  wire logic                                clk,
	input  wire logic signed [jabl_pkg::NUM_W-1:0]   num,
	input  wire logic        [jabl_pkg::FAC_W-1:0]   factor,
	output logic signed      [jabl_pkg::Q_W-1:0]     bound
);
	import jabl_pkg::*;

	// The 49 x 40 product is split into four partial products, summed over two
	// stages, then rounded to Q16.16 and saturated to 32 bits.
	logic        [43:0] pp_ll_s1;
	logic        [43:0] pp_lh_s1;
	logic signed [45:0] pp_hl_s1;
	logic signed [45:0] pp_hh_s1;
	logic signed [66:0] pair_hi_s2;
	logic        [64:0] pair_lo_s2;
	logic signed [90:0] total_s3;
	logic        [43:0] total_top;
	logic               in_range;

	always_ff @(posedge clk) begin
		pp_ll_s1 <= 44'(num[23:0]) * 44'(factor[19:0]);
		pp_lh_s1 <= 44'(num[23:0]) * 44'(factor[39:20]);
		pp_hl_s1 <= 46'($signed(num[48:24])) * 46'($signed({1'b0, factor[19:0]}));
		pp_hh_s1 <= 46'($signed(num[48:24])) * 46'($signed({1'b0, factor[39:20]}));
	end

	// The rounding half LSB is folded into the low pair.
	always_ff @(posedge clk) begin
		pair_hi_s2 <= (67'(pp_hh_s1) <<< 20) + 67'(pp_hl_s1);
		pair_lo_s2 <= (65'(pp_lh_s1) << 20) + 65'(pp_ll_s1) + 65'(1 << (Q_FRAC - 1));
	end

	always_ff @(posedge clk) begin
		total_s3 <= (91'(pair_hi_s2) <<< 24) + $signed(91'(pair_lo_s2));
	end

	assign total_top = total_s3[90:47];
	assign in_range  = (&total_top) | ~(|total_top);

	always_ff @(posedge clk) begin
		if (in_range) begin
			bound <= $signed(total_s3[47:16]);
		end else if (total_s3[90]) begin
			bound <= SAT_MIN;
		end else begin
			bound <= SAT_MAX;
		end
	end

endmodule
`default_nettype wire

/* rtl/joint_accel_bound_limiter_top.sv */
// A result appears on done together with its registered accel_upper and accel_lower.
// Throughput: one item per cycle; busy is never raised and cfg_ready is always high.
// The multipliers of the four bound lanes set the pipeline depth.
// Reset clears all valid bits and loads the default horizon and reciprocal registers.
`default_nettype none
`include "joint_accel_bound_limiter_top_defines.svh"
module joint_accel_bound_limiter_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [jabl_pkg::Q_W-1:0]       joint_position,
	input  wire logic signed [jabl_pkg::Q_W-1:0]       joint_velocity,
	input  wire logic signed [jabl_pkg::Q_W-1:0]       neutral_position,
	input  wire logic signed [jabl_pkg::Q_W-1:0]       position_max,
	input  wire logic signed [jabl_pkg::Q_W-1:0]       position_min,
	input  wire logic        [jabl_pkg::LIM_W-1:0]     velocity_max,
	input  wire logic        [jabl_pkg::LIM_W-1:0]     accel_max,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic        [jabl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [jabl_pkg::FAC_W-1:0]     cfg_data,
	output logic                                       done,
	output logic signed      [jabl_pkg::Q_W-1:0]       accel_upper,
	output logic signed      [jabl_pkg::Q_W-1:0]       accel_lower
);
	import jabl_pkg::*;

	logic [STEP_W-1:0] step_time_q;
	logic [FAC_W-1:0]  inverse_step_q;
	logic [FAC_W-1:0]  two_over_sq_q;

	logic [LATENCY-1:0] valid_q;
	logic               accept;
	logic               step_write;

	logic signed [63:0]     drift_prod_s1;
	logic signed [32:0]     rel_s1;
	logic signed [Q_W-1:0]  pmax_s1;
	logic signed [Q_W-1:0]  pmin_s1;
	logic signed [32:0]     vnum_up_s1;
	logic signed [32:0]     vnum_lo_s1;

	logic signed [63:0]     drift_round;
	logic signed [46:0]     drift_s2;
	logic signed [33:0]     pdiff_up_s2;
	logic signed [33:0]     pdiff_lo_s2;
	logic signed [32:0]     vnum_up_s2;
	logic signed [32:0]     vnum_lo_s2;

	logic signed [NUM_W-1:0] pnum_up_s3;
	logic signed [NUM_W-1:0] pnum_lo_s3;
	logic signed [NUM_W-1:0] vnum_up_s3;
	logic signed [NUM_W-1:0] vnum_lo_s3;

	logic signed [Q_W-1:0]  p_up_bound;
	logic signed [Q_W-1:0]  p_lo_bound;
	logic signed [Q_W-1:0]  v_up_bound;
	logic signed [Q_W-1:0]  v_lo_bound;

	logic [LIM_W-1:0] amax_s1;
	logic [LIM_W-1:0] amax_s2;
	logic [LIM_W-1:0] amax_s3;
	logic [LIM_W-1:0] amax_s4;
	logic [LIM_W-1:0] amax_s5;
	logic [LIM_W-1:0] amax_s6;
	logic [LIM_W-1:0] amax_s7;
	logic [LIM_W-1:0] amax_s8;

	logic signed [Q_W-1:0] amax_pos7;
	logic signed [Q_W-1:0] amax_neg7;
	logic signed [Q_W-1:0] up_min;
	logic signed [Q_W-1:0] lo_max;
	logic signed [Q_W-1:0] up_s8;
	logic signed [Q_W-1:0] lo_s8;

	logic signed [Q_W-1:0] amax_pos8;
	logic signed [Q_W-1:0] amax_neg8;
	logic signed [Q_W-1:0] hi_sw;
	logic signed [Q_W-1:0] lo_sw;

	// The pipeline never stalls, so items and register writes are always taken.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	assign step_write = cfg_valid & cfg_ready & (cfg_index == REG_STEP_TIME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q    <= STEP_TIME_RST;
			inverse_step_q <= INVERSE_RST;
			two_over_sq_q  <= TWO_OVER_SQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_STEP_TIME:    step_time_q    <= cfg_data[STEP_W-1:0];
				REG_INVERSE_STEP: inverse_step_q <= cfg_data;
				REG_TWO_OVER_SQ:  two_over_sq_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[LATENCY-2:0], accept};
		end
	end

	// Stage 1: velocity times horizon, relative position, velocity numerators.
	always_ff @(posedge clk) begin
		drift_prod_s1 <= 64'(joint_velocity) * 64'($signed({1'b0, step_time_q}));
		rel_s1        <= 33'(joint_position) - 33'(neutral_position);
		pmax_s1       <= position_max;
		pmin_s1       <= position_min;
		vnum_up_s1    <= $signed({2'b00, velocity_max}) - 33'(joint_velocity);
		vnum_lo_s1    <= -$signed({2'b00, velocity_max}) - 33'(joint_velocity);
		amax_s1       <= accel_max;
	end

	// Stage 2: round the drift term to Q16.16 and subtract the relative position.
	assign drift_round = drift_prod_s1 + 64'sd32768;

	always_ff @(posedge clk) begin
		drift_s2    <= $signed(drift_round[62:16]);
		pdiff_up_s2 <= 34'(pmax_s1) - 34'(rel_s1);
		pdiff_lo_s2 <= 34'(pmin_s1) - 34'(rel_s1);
		vnum_up_s2  <= vnum_up_s1;
		vnum_lo_s2  <= vnum_lo_s1;
		amax_s2     <= amax_s1;
	end

	// Stage 3: finish the position numerators.
	always_ff @(posedge clk) begin
		pnum_up_s3 <= NUM_W'(pdiff_up_s2) - NUM_W'(drift_s2);
		pnum_lo_s3 <= NUM_W'(pdiff_lo_s2) - NUM_W'(drift_s2);
		vnum_up_s3 <= NUM_W'(vnum_up_s2);
		vnum_lo_s3 <= NUM_W'(vnum_lo_s2);
		amax_s3    <= amax_s2;
	end

	// Stages 4 to 7: scaled and saturated bounds.
	jabl_scale u_scale_p_up (
		.clk    (clk),
		.num    (pnum_up_s3),
		.factor (two_over_sq_q),
		.bound  (p_up_bound)
	);

	jabl_scale u_scale_p_lo (
		.clk    (clk),
		.num    (pnum_lo_s3),
		.factor (two_over_sq_q),
		.bound  (p_lo_bound)
	);

	jabl_scale u_scale_v_up (
		.clk    (clk),
		.num    (vnum_up_s3),
		.factor (inverse_step_q),
		.bound  (v_up_bound)
	);

	jabl_scale u_scale_v_lo (
		.clk    (clk),
		.num    (vnum_lo_s3),
		.factor (inverse_step_q),
		.bound  (v_lo_bound)
	);

	always_ff @(posedge clk) begin
		amax_s4 <= amax_s3;
		amax_s5 <= amax_s4;
		amax_s6 <= amax_s5;
		amax_s7 <= amax_s6;
		amax_s8 <= amax_s7;
	end

	// Stage 8: tightest bound on each side.
	assign amax_pos7 = $signed({1'b0, amax_s7});
	assign amax_neg7 = -amax_pos7;

	always_comb begin
		up_min = (p_up_bound < v_up_bound) ? p_up_bound : v_up_bound;
		if (amax_pos7 < up_min) begin
			up_min = amax_pos7;
		end
		lo_max = (p_lo_bound > v_lo_bound) ? p_lo_bound : v_lo_bound;
		if (amax_neg7 > lo_max) begin
			lo_max = amax_neg7;
		end
	end

	always_ff @(posedge clk) begin
		up_s8 <= up_min;
		lo_s8 <= lo_max;
	end

	// Stage 9: swap crossed bounds, then clamp to the acceleration limit.
	assign amax_pos8 = $signed({1'b0, amax_s8});
	assign amax_neg8 = -amax_pos8;
	assign hi_sw     = (up_s8 < lo_s8) ? lo_s8 : up_s8;
	assign lo_sw     = (up_s8 < lo_s8) ? up_s8 : lo_s8;

	always_ff @(posedge clk) begin
		accel_upper <= (hi_sw > amax_pos8) ? amax_pos8 : hi_sw;
		accel_lower <= (lo_sw < amax_neg8) ? amax_neg8 : lo_sw;
	end

	assign done = valid_q[LATENCY-1];

	`JABL_ASSERT_IMPL(a_done_latency, done, $past(accept, LATENCY), "done without an item")
	`JABL_ASSERT_IMPL(a_bounds_ordered, done, accel_lower <= accel_upper, "bounds crossed")
	`JABL_ASSERT_NEXT(a_cfg_step, step_write, step_time_q == $past(STEP_W'(cfg_data)), "step lost")

endmodule
`default_nettype wire
